// ===== hw/rtl/pss_pkg.sv =====
// Shared types and constants for the process slot scheduler.
// Used by pss_ctrl, pss_datapath and process_slot_scheduler; depends on nothing.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int SLOT_W     = 3;
  localparam int SLOT_LIMIT = 8;   // slots that can ever be addressed or ready
  localparam int MASK_W     = 8;
  localparam int PRIO_W     = 8;
  localparam int AGE_W      = 16;
  localparam int KIND_W     = 2;
  localparam int STRAT_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index of the strategy register on the configuration port.
  localparam logic REG_STRATEGY = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHEDULE = 2'd0,
    KIND_START    = 2'd1,
    KIND_RESET    = 2'd2
  } kind_e;

  typedef enum logic [STRAT_W-1:0] {
    STRAT_EVEN   = 2'd0,
    STRAT_RR     = 2'd1,
    STRAT_AGING  = 2'd2,
    STRAT_RTC    = 2'd3
  } strat_e;

  typedef enum logic [1:0] {
    EMIT_PICK     = 2'd0,
    EMIT_KEEP     = 2'd1,
    EMIT_KEEP_DEC = 2'd2
  } emit_mode_e;

  typedef struct packed {
    logic       load;
    logic       start_write;
    logic       slice_from_cur;
    logic       clear_ages;
    logic       scan_init;
    logic       from_one;
    logic       scan_step;
    logic       aging;
    logic       pick_rr;
    logic       emit;
    emit_mode_e emit_mode;
  } pss_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  running;
    logic  slice_zero;
    logic  scan_last;
    logic  out_free;
  } pss_stat_t;

endpackage

// ===== hw/rtl/pss_datapath.sv =====
// Datapath of the process slot scheduler: item latch, priority and age tables,
// time slice, slot scan unit and result register. Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_datapath #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pss_pkg::KIND_W-1:0]     in_kind,
  input  logic [pss_pkg::SLOT_W-1:0]     in_current_slot,
  input  logic [pss_pkg::MASK_W-1:0]     in_ready_mask,
  input  logic                           in_current_running,
  input  logic [pss_pkg::SLOT_W-1:0]     in_start_slot,
  input  logic [pss_pkg::PRIO_W-1:0]     in_start_priority,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pss_pkg::SLOT_W-1:0]     out_next_slot,
  output logic [pss_pkg::PRIO_W-1:0]     out_slice_left,
  input  pss_pkg::pss_cmd_t              cmd,
  output pss_pkg::pss_stat_t             stat
);

  // Slots at or above the ready-mask width can never be ready or started,
  // so only the lower ones are stored.
  localparam int ENTRIES = (SLOT_COUNT < pss_pkg::SLOT_LIMIT) ? SLOT_COUNT
                                                               : pss_pkg::SLOT_LIMIT;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SUM_W   = pss_pkg::AGE_W + 1;
  localparam logic [pss_pkg::SLOT_W:0]   ENTRIES_V = (pss_pkg::SLOT_W+1)'(ENTRIES);
  localparam logic [pss_pkg::SLOT_W-1:0] LAST_SLOT = pss_pkg::SLOT_W'(ENTRIES - 1);
  localparam logic [pss_pkg::SLOT_W-1:0] SLOT_ONE  = pss_pkg::SLOT_W'(1);

  // Tables and slice (reset to zero).
  logic [pss_pkg::PRIO_W-1:0] prio_r [ENTRIES];
  logic [pss_pkg::PRIO_W-1:0] prio_nxt [ENTRIES];
  logic [pss_pkg::AGE_W-1:0]  age_r [ENTRIES];
  logic [pss_pkg::AGE_W-1:0]  age_nxt [ENTRIES];
  logic [pss_pkg::PRIO_W-1:0] slice_r, slice_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Latched item and scan working registers.
  pss_pkg::kind_e             kind_r, kind_nxt;
  logic [pss_pkg::SLOT_W-1:0] cur_r, cur_nxt;
  logic [pss_pkg::MASK_W-1:0] mask_r, mask_nxt;
  logic                       running_r, running_nxt;
  logic [pss_pkg::SLOT_W-1:0] sslot_r, sslot_nxt;
  logic [pss_pkg::PRIO_W-1:0] sprio_r, sprio_nxt;
  logic [pss_pkg::SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [pss_pkg::SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [pss_pkg::SLOT_W-1:0] best_r, best_nxt;
  logic [pss_pkg::AGE_W-1:0]  best_age_r, best_age_nxt;
  logic [pss_pkg::PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic                       have_r, have_nxt;
  logic [pss_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [pss_pkg::PRIO_W-1:0] out_slice_r, out_slice_nxt;

  logic [IDX_W-1:0]           ptr_idx, cur_idx, best_idx, sslot_idx;
  logic                       ptr_ready;
  logic [SUM_W-1:0]           age_sum;
  logic [pss_pkg::AGE_W-1:0]  step_age;
  logic                       better;
  logic                       out_free;

  assign ptr_idx   = ptr_r[IDX_W-1:0];
  assign cur_idx   = cur_r[IDX_W-1:0];
  assign best_idx  = best_r[IDX_W-1:0];
  assign sslot_idx = sslot_r[IDX_W-1:0];
  assign ptr_ready = mask_r[ptr_r];
  assign out_free  = !out_valid_r || !out_stall;

  assign age_sum = {1'b0, age_r[ptr_idx]} + SUM_W'(prio_r[ptr_idx]);

  always_comb begin
    if (cmd.aging && ptr_ready && (ptr_r != cur_r)) begin
      step_age = age_sum[SUM_W-1] ? '1 : age_sum[pss_pkg::AGE_W-1:0];
    end else begin
      step_age = age_r[ptr_idx];
    end
  end

  // Aging picks the oldest, then the higher priority; the ascending scan
  // settles remaining ties to the lower slot. Other scans take the first hit.
  assign better = ptr_ready &&
                  (!have_r ||
                   (cmd.aging && ((step_age > best_age_r) ||
                                  ((step_age == best_age_r) &&
                                   (prio_r[ptr_idx] > best_prio_r)))));

  always_comb begin
    prio_nxt      = prio_r;
    age_nxt       = age_r;
    slice_nxt     = slice_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    cur_nxt       = cur_r;
    mask_nxt      = mask_r;
    running_nxt   = running_r;
    sslot_nxt     = sslot_r;
    sprio_nxt     = sprio_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    best_age_nxt  = best_age_r;
    best_prio_nxt = best_prio_r;
    have_nxt      = have_r;
    out_slot_nxt  = out_slot_r;
    out_slice_nxt = out_slice_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      kind_nxt    = pss_pkg::kind_e'(in_kind);
      cur_nxt     = ({1'b0, in_current_slot} < ENTRIES_V) ? in_current_slot : '0;
      mask_nxt    = in_ready_mask;
      running_nxt = in_current_running;
      sslot_nxt   = in_start_slot;
      sprio_nxt   = in_start_priority;
    end

    if (cmd.start_write && ({1'b0, sslot_r} < ENTRIES_V)) begin
      prio_nxt[sslot_idx] = sprio_r;
      age_nxt[sslot_idx]  = '0;
    end

    if (cmd.slice_from_cur) begin
      slice_nxt = prio_r[cur_idx];
    end

    if (cmd.clear_ages) begin
      for (int i = 0; i < ENTRIES; i++) begin
        age_nxt[i] = '0;
      end
    end

    if (cmd.scan_init) begin
      if (cmd.from_one || (cur_r >= LAST_SLOT)) begin
        ptr_nxt = SLOT_ONE;
      end else begin
        ptr_nxt = cur_r + SLOT_ONE;
      end
      cnt_nxt  = LAST_SLOT;
      have_nxt = 1'b0;
      best_nxt = '0;
    end

    if (cmd.scan_step) begin
      if (cmd.aging) begin
        age_nxt[ptr_idx] = step_age;
      end
      if (better) begin
        best_nxt      = ptr_r;
        best_age_nxt  = step_age;
        best_prio_nxt = prio_r[ptr_idx];
        have_nxt      = 1'b1;
      end
      ptr_nxt = (ptr_r >= LAST_SLOT) ? SLOT_ONE : ptr_r + SLOT_ONE;
      cnt_nxt = cnt_r - SLOT_ONE;
    end

    if (cmd.emit) begin
      case (cmd.emit_mode)
        pss_pkg::EMIT_KEEP_DEC: begin
          out_slot_nxt = cur_r;
          slice_nxt    = slice_r - 1'b1;
        end
        pss_pkg::EMIT_KEEP: begin
          out_slot_nxt = cur_r;
        end
        pss_pkg::EMIT_PICK: begin
          out_slot_nxt = have_r ? best_r : '0;
          if (have_r && cmd.pick_rr) begin
            slice_nxt = best_prio_r;
          end
          if (have_r && cmd.aging) begin
            age_nxt[best_idx] = best_prio_r;
          end
        end
        default: begin
          out_slot_nxt = '0;
        end
      endcase
      out_slice_nxt = slice_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        prio_r[i] <= '0;
        age_r[i]  <= '0;
      end
      slice_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prio_r      <= prio_nxt;
      age_r       <= age_nxt;
      slice_r     <= slice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    cur_r       <= cur_nxt;
    mask_r      <= mask_nxt;
    running_r   <= running_nxt;
    sslot_r     <= sslot_nxt;
    sprio_r     <= sprio_nxt;
    ptr_r       <= ptr_nxt;
    cnt_r       <= cnt_nxt;
    best_r      <= best_nxt;
    best_age_r  <= best_age_nxt;
    best_prio_r <= best_prio_nxt;
    have_r      <= have_nxt;
    out_slot_r  <= out_slot_nxt;
    out_slice_r <= out_slice_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_next_slot  = out_slot_r;
  assign out_slice_left = out_slice_r;

  assign stat.kind       = kind_r;
  assign stat.running    = running_r;
  assign stat.slice_zero = (slice_r == '0);
  assign stat.scan_last  = (cnt_r == SLOT_ONE);
  assign stat.out_free   = out_free;

endmodule

// ===== hw/rtl/pss_ctrl.sv =====
// Controller of the process slot scheduler: sequences decode of each accepted beat
// and, for schedule calls, slot scan and result hand-off. Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pss_pkg::STRAT_W-1:0]       strategy,
  input  pss_pkg::pss_stat_t                stat,
  output pss_pkg::pss_cmd_t                 cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  pss_pkg::emit_mode_e  mode_r, mode_nxt;
  pss_pkg::strat_e      strat;

  assign strat    = pss_pkg::strat_e'(strategy);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    cmd.emit_mode = mode_r;
    cmd.aging     = (strat == pss_pkg::STRAT_AGING);
    cmd.pick_rr   = (strat == pss_pkg::STRAT_RR);

    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          pss_pkg::KIND_START: begin
            cmd.start_write = 1'b1;
            state_nxt       = ST_IDLE;
          end
          pss_pkg::KIND_RESET: begin
            cmd.slice_from_cur = (strat == pss_pkg::STRAT_RR);
            cmd.clear_ages     = (strat == pss_pkg::STRAT_AGING);
            state_nxt          = ST_IDLE;
          end
          pss_pkg::KIND_SCHEDULE: begin
            if ((strat == pss_pkg::STRAT_RR) && !stat.slice_zero) begin
              mode_nxt  = pss_pkg::EMIT_KEEP_DEC;
              state_nxt = ST_EMIT;
            end else if ((strat == pss_pkg::STRAT_RTC) && stat.running) begin
              mode_nxt  = pss_pkg::EMIT_KEEP;
              state_nxt = ST_EMIT;
            end else begin
              // Aging and run to completion scan upwards from slot one.
              cmd.scan_init = 1'b1;
              cmd.from_one  = (strat == pss_pkg::STRAT_AGING) ||
                              (strat == pss_pkg::STRAT_RTC);
              mode_nxt      = pss_pkg::EMIT_PICK;
              state_nxt     = ST_SCAN;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= pss_pkg::EMIT_PICK;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

// ===== hw/rtl/process_slot_scheduler.sv =====
// Top level of the process slot scheduler: configuration register port and
// the controller and datapath. Depends on pss_pkg, pss_ctrl and pss_datapath.
//
// Picks the next of SLOT_COUNT process slots (slot 0 is the idle process) under
// one of four strategies set in the strategy register at byte address 0: even,
// round robin, inactive aging and run to completion. Only slots 1 to
// min(SLOT_COUNT,8)-1 can be ready. A beat is taken only while in_stall is low
// and a new beat is taken once the previous one has been worked through, even
// while a result still waits on the output register. A process start or
// strategy reset beat passes through decode and gives no result. A schedule
// call that keeps the current slot goes from decode to emit; one that scans
// passes through the scan state, where the scan unit visits one slot per cycle,
// before emit. Write the strategy only while idle.
`timescale 1ns / 1ps

module process_slot_scheduler #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pss_pkg::KIND_W-1:0]         in_kind,
  input  logic [pss_pkg::SLOT_W-1:0]         in_current_slot,
  input  logic [pss_pkg::MASK_W-1:0]         in_ready_mask,
  input  logic                               in_current_running,
  input  logic [pss_pkg::SLOT_W-1:0]         in_start_slot,
  input  logic [pss_pkg::PRIO_W-1:0]         in_start_priority,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pss_pkg::SLOT_W-1:0]         out_next_slot,
  output logic [pss_pkg::PRIO_W-1:0]         out_slice_left,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pss_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pss_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  logic [pss_pkg::STRAT_W-1:0] strategy_r, strategy_nxt;
  logic                        reg_sel;
  pss_pkg::pss_cmd_t           cmd;
  pss_pkg::pss_stat_t          stat;

  // Registers are word spaced; the word index picks the register.
  assign reg_sel    = (cfg_paddr[2] == pss_pkg::REG_STRATEGY);
  assign cfg_pready = 1'b1;

  always_comb begin
    strategy_nxt = strategy_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      strategy_nxt = cfg_pwdata[pss_pkg::STRAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= pss_pkg::STRAT_EVEN;
    end else begin
      strategy_r <= strategy_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel) begin
      cfg_prdata[pss_pkg::STRAT_W-1:0] = strategy_r;
    end
  end

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .strategy (strategy_r),
    .stat     (stat),
    .cmd      (cmd)
  );

  pss_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_current_slot    (in_current_slot),
    .in_ready_mask      (in_ready_mask),
    .in_current_running (in_current_running),
    .in_start_slot      (in_start_slot),
    .in_start_priority  (in_start_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_slot      (out_next_slot),
    .out_slice_left     (out_slice_left),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule
